// ===== rtl/tlc_pkg.sv =====
// tlc_pkg: shared types and constants of the two-way lookup cache
// no dependencies; imported by the front, back and top level modules
`default_nettype none

package tlc_pkg;

    localparam int KEY_W = 64;
    localparam int VAL_W = 64;

    // item opcodes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // command kinds handed from front to back
    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_ZERO   = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    // set hash
    localparam logic [31:0] HASH_MULT      = 32'h9e37_79b1;
    localparam int          HASH_PRE_SHIFT = 4;
    localparam int          HASH_FOLD_A    = 16;
    localparam int          HASH_FOLD_B    = 13;

    // set index reduction weighs each byte of the 64-bit hash separately
    localparam int DIGIT_W     = 8;
    localparam int DIGIT_STEPS = 8;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] backing;
    } cmd_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             hit;
    } res_t;

    typedef struct packed {
        logic [KEY_W-1:0] tag;
        logic [VAL_W-1:0] value;
    } way_t;

    // one memory row holds a whole set
    typedef struct packed {
        logic victim;
        way_t way1;
        way_t way0;
    } row_t;

endpackage

`default_nettype wire

// ===== rtl/tlc_ram.sv =====
// tlc_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module tlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/tlc_fifo.sv =====
// tlc_fifo: small first-in first-out queue in flip-flops
// no dependencies; used between front and back and on the result side
`default_nettype none

module tlc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tlc_front.sv =====
// tlc_front: takes items, classifies them and computes the set index
// depends on tlc_pkg; feeds the command queue toward tlc_back
`default_nettype none

module tlc_front
    import tlc_pkg::*;
#(
    parameter int SET_COUNT = 16,
    parameter int SET_W     = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic             opcode,
    input  wire logic [KEY_W-1:0] lookup_key,
    input  wire logic [VAL_W-1:0] backing_value,
    output logic                  busy,
    output logic                  cmd_valid,
    output cmd_t                  cmd,
    output logic      [SET_W-1:0] cmd_set,
    input  wire logic             cmd_full
);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_MUL  = 3'd1;
    localparam logic [2:0] F_ADD  = 3'd2;
    localparam logic [2:0] F_FOLD = 3'd3;
    localparam logic [2:0] F_QUOT = 3'd4;
    localparam logic [2:0] F_REM  = 3'd5;
    localparam logic [2:0] F_PUSH = 3'd6;

    // weighted byte sum stays below DIGIT_STEPS * 2^(DIGIT_W + SET_W)
    localparam int          FOLD_W = DIGIT_W + SET_W + $clog2(DIGIT_STEPS);
    localparam int          PROD_W = FOLD_W + 32;
    // floor(2^32 / SET_COUNT): the quotient estimate is exact or one short
    localparam logic [31:0] RECIP  = 32'((64'd1 << 32) / 64'(SET_COUNT));

    logic [2:0]        state_reg, state_next;
    logic              op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  back_reg;
    logic [63:0]       pl_reg, pl_next;
    logic [31:0]       ph_reg, ph_next;
    logic [63:0]       h_reg, h_next;
    logic [FOLD_W-1:0] fold_reg;
    logic [FOLD_W-1:0] q_reg;
    logic [SET_W-1:0]  rem_reg, rem_next;

    logic [63:0]       k_pre, g_fold, h_sum;
    logic [FOLD_W-1:0] byte_part [DIGIT_STEPS];
    logic [FOLD_W-1:0] fold_sum;
    logic [PROD_W-1:0] q_prod;
    logic [FOLD_W-1:0] r_est;

    // first fold of the hash, then the 60x32 product split in two halves
    assign k_pre  = key_reg >> HASH_PRE_SHIFT;
    assign g_fold = k_pre ^ (k_pre >> HASH_FOLD_A);
    assign pl_next = 64'(g_fold[31:0]) * 64'(HASH_MULT);
    assign ph_next = g_fold[63:32] * HASH_MULT;
    assign h_sum   = pl_reg + {ph_reg, 32'd0};

    // each hash byte weighted by 2^(8k) mod SET_COUNT keeps the same residue
    for (genvar k = 0; k < DIGIT_STEPS; k++)
    begin : g_byte
        localparam logic [SET_W-1:0] BYTE_RES =
            SET_W'((64'd1 << (DIGIT_W * k)) % 64'(SET_COUNT));
        assign byte_part[k] = FOLD_W'(h_reg[DIGIT_W*k +: DIGIT_W]) * FOLD_W'(BYTE_RES);
    end

    always_comb
    begin
        fold_sum = '0;
        for (int j = 0; j < DIGIT_STEPS; j++)
        begin
            fold_sum = fold_sum + byte_part[j];
        end
    end

    // reciprocal multiply, then one correcting subtract
    assign q_prod = PROD_W'(fold_reg) * PROD_W'(RECIP);
    assign r_est  = fold_reg - q_reg * FOLD_W'(SET_COUNT);

    always_comb
    begin
        state_next = state_reg;
        h_next     = h_reg;
        rem_next   = rem_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_FLUSH || lookup_key == '0)
                    begin
                        state_next = F_PUSH;
                    end
                    else
                    begin
                        state_next = F_MUL;
                    end
                end
            end
            F_MUL:
            begin
                state_next = F_ADD;
            end
            F_ADD:
            begin
                h_next     = h_sum ^ (h_sum >> HASH_FOLD_B);
                state_next = F_FOLD;
            end
            F_FOLD:
            begin
                state_next = F_QUOT;
            end
            F_QUOT:
            begin
                state_next = F_REM;
            end
            F_REM:
            begin
                if (r_est >= FOLD_W'(SET_COUNT))
                begin
                    rem_next = SET_W'(r_est - FOLD_W'(SET_COUNT));
                end
                else
                begin
                    rem_next = SET_W'(r_est);
                end
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!cmd_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && accept)
        begin
            op_reg   <= opcode;
            key_reg  <= lookup_key;
            back_reg <= backing_value;
        end
        pl_reg   <= pl_next;
        ph_reg   <= ph_next;
        h_reg    <= h_next;
        fold_reg <= fold_sum;
        q_reg    <= q_prod[PROD_W-1:32];
        rem_reg  <= rem_next;
    end

    always_comb
    begin
        if (op_reg == OP_FLUSH)
        begin
            cmd.kind = CMD_FLUSH;
        end
        else if (key_reg == '0)
        begin
            cmd.kind = CMD_ZERO;
        end
        else
        begin
            cmd.kind = CMD_LOOKUP;
        end
        cmd.key     = key_reg;
        cmd.backing = back_reg;
    end

    assign cmd_set   = rem_reg;
    assign cmd_valid = (state_reg == F_PUSH);
    assign busy      = (state_reg != F_IDLE);

endmodule

`default_nettype wire

// ===== rtl/tlc_back.sv =====
// tlc_back: carries out lookups, fills and flushes on the set memory
// depends on tlc_pkg and tlc_ram
`default_nettype none

module tlc_back
    import tlc_pkg::*;
#(
    parameter int SET_COUNT = 16,
    parameter int SET_W     = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_empty,
    input  cmd_t                  cmd,
    input  wire logic [SET_W-1:0] cmd_set,
    output logic                  cmd_pop,
    input  wire logic             res_full,
    output logic                  res_push,
    output res_t                  res_data,
    output logic                  clearing
);

    localparam logic [1:0] B_CLEAR = 2'd0;
    localparam logic [1:0] B_IDLE  = 2'd1;
    localparam logic [1:0] B_LOOK  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [SET_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0] back_reg, back_next;
    logic [SET_W-1:0] set_reg, set_next;

    logic             ram_we, ram_re;
    logic [SET_W-1:0] ram_waddr, ram_raddr;
    row_t             ram_wdata, rd_row, row_new;
    logic             hit0, hit1, pick;

    tlc_ram #(
        .WIDTH ($bits(row_t)),
        .DEPTH (SET_COUNT)
    ) u_set_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_row)
    );

    // a way hits when it holds a value and its tag matches
    assign hit0 = (rd_row.way0.value != '0) && (rd_row.way0.tag == key_reg);
    assign hit1 = (rd_row.way1.value != '0) && (rd_row.way1.tag == key_reg);

    // replacement: empty way 0, then empty way 1, else victim
    always_comb
    begin
        if (rd_row.way0.value == '0)
        begin
            pick = 1'b0;
        end
        else if (rd_row.way1.value == '0)
        begin
            pick = 1'b1;
        end
        else
        begin
            pick = rd_row.victim;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        key_next     = key_reg;
        back_next    = back_reg;
        set_next     = set_reg;
        cmd_pop      = 1'b0;
        res_push     = 1'b0;
        res_data     = '0;
        ram_we       = 1'b0;
        ram_waddr    = clr_cnt_reg;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = cmd_set;
        row_new      = rd_row;
        case (state_reg)
            B_CLEAR:
            begin
                ram_we = 1'b1;
                if (clr_cnt_reg == SET_W'(SET_COUNT - 1))
                begin
                    state_next = B_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            B_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        CMD_FLUSH:
                        begin
                            clr_cnt_next = '0;
                            state_next   = B_CLEAR;
                        end
                        CMD_ZERO:
                        begin
                            res_push = 1'b1;
                        end
                        CMD_LOOKUP:
                        begin
                            ram_re     = 1'b1;
                            key_next   = cmd.key;
                            back_next  = cmd.backing;
                            set_next   = cmd_set;
                            state_next = B_LOOK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            B_LOOK:
            begin
                res_push   = 1'b1;
                state_next = B_IDLE;
                ram_waddr  = set_reg;
                if (hit0)
                begin
                    res_data.value = rd_row.way0.value;
                    res_data.hit   = 1'b1;
                    row_new.victim = 1'b1;
                    ram_we         = 1'b1;
                end
                else if (hit1)
                begin
                    res_data.value = rd_row.way1.value;
                    res_data.hit   = 1'b1;
                    row_new.victim = 1'b0;
                    ram_we         = 1'b1;
                end
                else
                begin
                    res_data.value = back_reg;
                    res_data.hit   = 1'b0;
                    if (back_reg != '0)
                    begin
                        ram_we = 1'b1;
                        if (pick)
                        begin
                            row_new.way1.tag   = key_reg;
                            row_new.way1.value = back_reg;
                        end
                        else
                        begin
                            row_new.way0.tag   = key_reg;
                            row_new.way0.value = back_reg;
                        end
                        row_new.victim = ~pick;
                    end
                end
                ram_wdata = row_new;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        back_reg <= back_next;
        set_reg  <= set_next;
    end

    assign clearing = (state_reg == B_CLEAR);

`ifndef SYNTHESIS
    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLEAR) |-> !res_push)
        else $error("result produced during clearing pass");

    a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("set memory read and written in one cycle");

    a_look_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_LOOK) |=> (state_reg == B_IDLE))
        else $error("lookup did not finish in one cycle");

    a_clear_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        clr_cnt_reg <= SET_W'(SET_COUNT - 1))
        else $error("clearing counter out of range");

    a_look_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_LOOK) |-> !res_full)
        else $error("lookup result with no room in result queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/two_way_lookup_cache_core.sv =====
// two_way_lookup_cache_core: top level of the two-way lookup cache
// depends on tlc_pkg, tlc_front, tlc_fifo, tlc_back (and tlc_ram through tlc_back)
`default_nettype none

// Two-way set-associative cache in front of a slower key-to-value table.
// Each item is a lookup (key plus the value the backing table holds, 0 meaning
// absent) or a flush. A lookup returns one result: the cached value with
// was_hit set, or else the backing value, which is then filled into the set
// when nonzero (empty way 0 first, then empty way 1, else the victim way).
// A zero key returns 0 and changes nothing; a flush returns no result and
// empties the whole cache. Both sides behave as queues: push/full on the
// input, empty/pop on the results, with a two-entry result queue so up to two
// finished results wait without holding up the cache. The front end takes one
// item at a time: a lookup passes from the accepting state through a multiply
// state, an add state, then fold, quotient and remainder states that reduce the
// hash to a set index by a weighted byte sum and a reciprocal multiply, and a
// push state that hands the command over, waiting while the command queue is
// full; a flush or zero-key item goes from the accepting state to the push state.
// The back end reads a set (registered read) and then updates it, so the
// front end's set-index computation sets the rate. After reset and every
// flush, the back end sweeps the set memory one set per cycle, holding full high.
module two_way_lookup_cache_core
    import tlc_pkg::*;
#(
    parameter int SET_COUNT = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // input side
    input  wire logic             push,
    output logic                  full,
    input  wire logic             opcode,
    input  wire logic [KEY_W-1:0] lookup_key,
    input  wire logic [VAL_W-1:0] backing_value,
    // result side
    output logic                  empty,
    input  wire logic             pop,
    output logic      [VAL_W-1:0] result_value,
    output logic                  was_hit
);

    localparam int SET_W   = $clog2(SET_COUNT);
    localparam int CMD_W   = $bits(cmd_t) + SET_W;
    localparam int Q_DEPTH = 2;

    // front end handshake
    logic             accept;
    logic             front_busy;
    logic             clearing;

    // command queue between front and back
    logic             cmd_valid;
    cmd_t             cmd_in, cmd_out;
    logic [SET_W-1:0] cmd_set_in, cmd_set_out;
    logic             cmd_full, cmd_empty, cmd_pop;
    logic [CMD_W-1:0] cmd_q_out;

    // result queue
    logic             res_push, res_full;
    res_t             res_in, res_out;

    // nothing enters while the front end is busy or the memory is being swept
    assign full   = front_busy || clearing;
    assign accept = push && !full;

    tlc_front #(
        .SET_COUNT (SET_COUNT),
        .SET_W     (SET_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .opcode        (opcode),
        .lookup_key    (lookup_key),
        .backing_value (backing_value),
        .busy          (front_busy),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd_in),
        .cmd_set       (cmd_set_in),
        .cmd_full      (cmd_full)
    );

    // command transactions carry the classified item plus its set index
    tlc_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (Q_DEPTH)
    ) u_cmd_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_valid),
        .push_data ({cmd_in, cmd_set_in}),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_q_out),
        .empty     (cmd_empty)
    );

    assign cmd_out     = cmd_q_out[CMD_W-1:SET_W];
    assign cmd_set_out = cmd_q_out[SET_W-1:0];

    tlc_back #(
        .SET_COUNT (SET_COUNT),
        .SET_W     (SET_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_set   (cmd_set_out),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_in),
        .clearing  (clearing)
    );

    // finished results wait here until popped
    tlc_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (Q_DEPTH)
    ) u_res_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_out),
        .empty     (empty)
    );

    assign result_value = res_out.value;
    assign was_hit      = res_out.hit;

endmodule

`default_nettype wire
